// ----- design/mie_angular_pi_tau_series_defines.svh -----
// Assertion macros shared by the angular function series design.
`ifndef MIE_ANGULAR_PI_TAU_SERIES_DEFINES_SVH
`define MIE_ANGULAR_PI_TAU_SERIES_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Holds on every clock edge outside reset.
`define MPT_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

// Consequent holds in the same cycle as the antecedent.
`define MPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Consequent holds in the cycle after the antecedent.
`define MPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define MPT_ASSERT_ALWAYS(label, expr)
`define MPT_ASSERT_IMP(label, ante, cons)
`define MPT_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- design/mpt_pkg.sv -----
// Shared widths, types and helpers of the angular function series block.
package mpt_pkg;

  localparam int ORDER_MAX_DEF  = 64;
  localparam int DIVISOR_W_DEF  = 6;

  localparam int ORDER_W   = 7;
  localparam int COS_W     = 18;
  localparam int MU_MAG_W  = 17;
  localparam int VAL_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int HALF_W    = 24;
  localparam int PART_W    = MU_MAG_W + HALF_W;
  localparam int ACC_W     = 64;
  localparam int R_W       = VAL_W + 1;
  localparam int WIDE_W    = 58;

  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 104;

  localparam int DIV_BITS  = 64;
  localparam int STEP_BITS = 8;
  localparam int DIV_CELLS = DIV_BITS / STEP_BITS;

  localparam logic signed [COS_W-1:0] COS_PLUS_ONE  = 18'sd65536;
  localparam logic signed [COS_W-1:0] COS_MINUS_ONE = -18'sd65536;
  localparam logic [VAL_W-1:0]        Q_ONE_VAL     = 48'd65536;
  localparam logic [ACC_W-1:0]        ROUND_HALF    = 64'd32768;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [DIV_BITS-1:0] QUO_POS_LIM = {{(DIV_BITS-VAL_W+1){1'b0}},
                                                 {(VAL_W-1){1'b1}}};
  localparam logic [DIV_BITS-1:0] QUO_NEG_LIM = {{(DIV_BITS-VAL_W){1'b0}}, 1'b1,
                                                 {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SIGN,
    ST_SCALE,
    ST_COMBINE,
    ST_EMIT,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_tag_t;

  // Clamp a wide signed value to the signed 48-bit range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] top;
    top = v[WIDE_W-1:VAL_W-1];
    if (top == '0 || top == '1) begin
      return v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

endpackage

// ----- design/mpt_div_cell.sv -----
// One cell of the divider row: eight restoring division steps, registered.
module mpt_div_cell #(
  parameter int DIV_W = mpt_pkg::DIVISOR_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpt_pkg::div_tag_t             tag_in,
  input  logic [mpt_pkg::DIV_BITS-1:0]  num_in,
  input  logic [mpt_pkg::DIV_BITS-1:0]  quo_in,
  input  logic [DIV_W-1:0]              rem_in,
  input  logic [DIV_W-1:0]              dvs_in,
  output mpt_pkg::div_tag_t             tag_out,
  output logic [mpt_pkg::DIV_BITS-1:0]  num_out,
  output logic [mpt_pkg::DIV_BITS-1:0]  quo_out,
  output logic [DIV_W-1:0]              rem_out,
  output logic [DIV_W-1:0]              dvs_out
);
  import mpt_pkg::*;

  logic [DIV_BITS-1:0] num_next;
  logic [DIV_BITS-1:0] quo_next;
  logic [DIV_W-1:0]    rem_next;

  // The remainder stays below the divisor, so each trial is only DIV_W+1 bits.
  always_comb begin
    logic [DIV_W-1:0]    r;
    logic [DIV_BITS-1:0] x;
    logic [DIV_BITS-1:0] q;
    logic [DIV_W:0]      trial;
    r = rem_in;
    x = num_in;
    q = quo_in;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, x[DIV_BITS-1]};
      x = {x[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_in}) begin
        r = DIV_W'(trial - {1'b0, dvs_in});
        q = {q[DIV_BITS-2:0], 1'b1};
      end else begin
        r = trial[DIV_W-1:0];
        q = {q[DIV_BITS-2:0], 1'b0};
      end
    end
    num_next = x;
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    num_out <= num_next;
    quo_out <= quo_next;
    rem_out <= rem_next;
    dvs_out <= dvs_in;
  end

endmodule

// ----- design/mpt_div_chain.sv -----
// Row of divider cells that turns a 64-bit magnitude into its quotient by a small divisor.
`include "mie_angular_pi_tau_series_defines.svh"

module mpt_div_chain #(
  parameter int DIV_W = mpt_pkg::DIVISOR_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpt_pkg::div_tag_t             in_tag,
  input  logic [mpt_pkg::DIV_BITS-1:0]  in_num,
  input  logic [DIV_W-1:0]              in_dvs,
  output mpt_pkg::div_tag_t             out_tag,
  output logic [mpt_pkg::DIV_BITS-1:0]  out_quo
);
  import mpt_pkg::*;

  div_tag_t            tag [DIV_CELLS+1];
  logic [DIV_BITS-1:0] num [DIV_CELLS+1];
  logic [DIV_BITS-1:0] quo [DIV_CELLS+1];
  logic [DIV_W-1:0]    rem [DIV_CELLS+1];
  logic [DIV_W-1:0]    dvs [DIV_CELLS+1];
  logic [DIV_CELLS-1:0] busy;

  assign tag[0] = in_tag;
  assign num[0] = in_num;
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign dvs[0] = in_dvs;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    mpt_div_cell #(
      .DIV_W(DIV_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tag_in  (tag[k]),
      .num_in  (num[k]),
      .quo_in  (quo[k]),
      .rem_in  (rem[k]),
      .dvs_in  (dvs[k]),
      .tag_out (tag[k+1]),
      .num_out (num[k+1]),
      .quo_out (quo[k+1]),
      .rem_out (rem[k+1]),
      .dvs_out (dvs[k+1])
    );
    assign busy[k] = tag[k+1].valid;
  end

  assign out_tag = tag[DIV_CELLS];
  assign out_quo = quo[DIV_CELLS];

  // Only one division is ever in the row, so at most one cell holds a valid item.
  `MPT_ASSERT_ALWAYS(a_single_division, $onehot0(busy))
  `MPT_ASSERT_IMP(a_rem_bound, out_tag.valid,
                  rem[DIV_CELLS] < dvs[DIV_CELLS] && num[DIV_CELLS] == '0)
  `MPT_ASSERT_IMP(a_chain_latency, out_tag.valid, $past(in_tag.valid, DIV_CELLS))

endmodule

// ----- design/mie_angular_pi_tau_series.sv -----
// Mie angular functions: an accepted item passes the MUL_LO, MUL_HI, SIGN, SCALE and COMBINE
// states, which use the shared 17x24 multiplier and the scaling, then EMIT, which waits while
// the output is stalled. Each further order goes through the divider row and those states again.
// A new item is accepted once the last result of the previous one is in the output register.
// Synchronous reset sets order_count to 64 and leaves the block idle with no result pending.
`include "mie_angular_pi_tau_series_defines.svh"

module mie_angular_pi_tau_series #(
  parameter int ORDER_MAX = mpt_pkg::ORDER_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mpt_pkg::ORDER_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mpt_pkg::S_DATA_W-1:0]  s_tdata,  // [17:0] angle_cosine, [23:18] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mpt_pkg::M_DATA_W-1:0]  m_tdata,  // [6:0] order_index, [54:7] pi_value,
                                                  // [102:55] tau_value, [103] zero
  output logic                          m_tlast   // last_order
);
  import mpt_pkg::*;

  localparam int DIV_W = $clog2(ORDER_MAX);

  state_t state, state_next;

  logic [ORDER_W-1:0] order_count;
  logic [ORDER_W-1:0] cnt;
  logic [ORDER_W-1:0] cnt_eff;
  logic [ORDER_W-1:0] n;
  logic [ORDER_W:0]   n_plus;

  logic signed [COS_W-1:0] cos_in;
  logic signed [COS_W-1:0] cos_clamped;
  logic                    mu_neg;
  logic [MU_MAG_W-1:0]     mu_mag;

  logic signed [VAL_W-1:0] pi_cur;
  logic signed [VAL_W-1:0] pi_prev;
  logic [VAL_W-1:0]        pin_mag;
  logic                    pin_neg;

  logic [HALF_W-1:0]       mul_half;
  logic [PART_W-1:0]       mul_part;
  logic [ACC_W-1:0]        acc;
  logic [VAL_W-1:0]        r_mag;
  logic signed [R_W-1:0]   r_s;
  logic signed [WIDE_W-1:0] a_prod;
  logic signed [WIDE_W-1:0] k_prod;
  logic signed [WIDE_W-1:0] t_num;
  logic [WIDE_W-1:0]       t_abs;
  logic signed [VAL_W-1:0] tau;

  logic                    is_last;
  logic                    out_load;
  logic                    div_launch;

  div_tag_t                div_in_tag;
  div_tag_t                div_out_tag;
  logic [DIV_BITS-1:0]     div_quo;
  logic [VAL_W-1:0]        quo_mag;
  logic signed [VAL_W-1:0] quo_val;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_count <= ORDER_W'(ORDER_MAX_DEF);
    end else if (cfg_write) begin
      order_count <= cfg_data;
    end
  end

  // A count of zero means one order; counts above the maximum are clipped.
  always_comb begin
    if (order_count == '0) begin
      cnt_eff = ORDER_W'(1);
    end else if (order_count > ORDER_W'(ORDER_MAX)) begin
      cnt_eff = ORDER_W'(ORDER_MAX);
    end else begin
      cnt_eff = order_count;
    end
  end

  assign cos_in = $signed(s_tdata[COS_W-1:0]);

  always_comb begin
    if (cos_in > COS_PLUS_ONE) begin
      cos_clamped = COS_PLUS_ONE;
    end else if (cos_in < COS_MINUS_ONE) begin
      cos_clamped = COS_MINUS_ONE;
    end else begin
      cos_clamped = cos_in;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MUL_LO;
      end
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_SIGN;
      ST_SIGN:    state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_COMBINE;
      ST_COMBINE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) state_next = is_last ? ST_IDLE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_out_tag.valid) state_next = ST_MUL_LO;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    is_last    = (n == cnt);
    s_tready   = (state == ST_IDLE);
    out_load   = (state == ST_EMIT) && (!m_tvalid || m_tready);
    div_launch = out_load && !is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier: |mu| times one half of |pi_n| per cycle.
  assign mul_half = (state == ST_MUL_HI) ? pin_mag[VAL_W-1:HALF_W] : pin_mag[HALF_W-1:0];
  assign mul_part = mu_mag * mul_half;
  assign r_mag    = acc[ACC_W-1:FRAC_W];
  assign n_plus   = {1'b0, n} + (ORDER_W+1)'(1);
  assign t_abs    = t_num[WIDE_W-1] ? WIDE_W'(-t_num) : WIDE_W'(t_num);

  // Saturate the truncated quotient to the signed 48-bit range.
  always_comb begin
    if (div_out_tag.neg) begin
      quo_mag = (div_quo > QUO_NEG_LIM) ? QUO_NEG_LIM[VAL_W-1:0] : div_quo[VAL_W-1:0];
    end else begin
      quo_mag = (div_quo > QUO_POS_LIM) ? QUO_POS_LIM[VAL_W-1:0] : div_quo[VAL_W-1:0];
    end
    quo_val = div_out_tag.neg ? $signed(-quo_mag) : $signed(quo_mag);
  end

  assign div_in_tag.valid = div_launch;
  assign div_in_tag.neg   = t_num[WIDE_W-1];

  mpt_div_chain #(
    .DIV_W(DIV_W)
  ) u_div_chain (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (div_in_tag),
    .in_num  (DIV_BITS'(t_abs)),
    .in_dvs  (n[DIV_W-1:0]),
    .out_tag (div_out_tag),
    .out_quo (div_quo)
  );

  // Recurrence datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mu_neg  <= cos_clamped[COS_W-1];
          mu_mag  <= cos_clamped[COS_W-1] ? MU_MAG_W'(-cos_clamped)
                                          : cos_clamped[MU_MAG_W-1:0];
          cnt     <= cnt_eff;
          n       <= ORDER_W'(1);
          pi_cur  <= $signed(Q_ONE_VAL);
          pin_mag <= Q_ONE_VAL;
          pin_neg <= 1'b0;
          pi_prev <= '0;
        end
      end
      ST_MUL_LO: begin
        acc <= ACC_W'(mul_part) + ROUND_HALF;
      end
      ST_MUL_HI: begin
        // The upper half of |pi_n| is at most 2^23, so the top product bit is clear.
        acc <= acc + {mul_part[PART_W-2:0], {HALF_W{1'b0}}};
      end
      ST_SIGN: begin
        r_s <= (mu_neg ^ pin_neg) ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
      end
      ST_SCALE: begin
        a_prod <= $signed({1'b0, n}) * r_s;
        k_prod <= $signed({1'b0, n_plus}) * pi_prev;
      end
      ST_COMBINE: begin
        // tau_n = n r - (n+1) pi_{n-1}; the next numerator adds (n+1) r to the same sum.
        tau   <= sat_val(a_prod - k_prod);
        t_num <= (a_prod <<< 1) + WIDE_W'(r_s) - k_prod;
      end
      ST_EMIT: begin
      end
      ST_DIVIDE: begin
        if (div_out_tag.valid) begin
          pi_prev <= pi_cur;
          pi_cur  <= quo_val;
          pin_mag <= quo_mag;
          pin_neg <= div_out_tag.neg;
          n       <= n + ORDER_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, tau, pi_cur, n};
      m_tlast <= is_last;
    end
  end

  `MPT_ASSERT_IMP(a_order_range, state != ST_IDLE, n != '0 && n <= cnt)
  `MPT_ASSERT_IMP(a_quotient_in_divide, div_out_tag.valid, state == ST_DIVIDE)
  `MPT_ASSERT_NXT(a_last_frees_input, out_load && is_last, s_tready)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Mie angular pi/tau series block, with its own order-by-order predictor.
module tb;
  import mpt_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_HOLD_CYCLES = 300;
  localparam longint RUN_LIMIT_CYCLES = 2_000_000;
  localparam longint Q16_ONE = 65536;
  localparam longint PI_MAX = 64'sd140737488355327;
  localparam longint PI_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [VAL_W-1:0]   pi_n;
    logic [VAL_W-1:0]   tau_n;
    logic               last;
  } order_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [ORDER_W-1:0]  cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  order_result_t      expected_orders[$];
  logic [ORDER_W-1:0] order_count_model = 7'd64;
  int                 mismatch_count = 0;
  int                 results_checked = 0;
  int                 angles_sent = 0;
  bit                 idle_enable = 1'b1;
  int unsigned        hold_request = 0;
  int unsigned        sink_wait = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  mie_angular_pi_tau_series #(
    .ORDER_MAX(ORDER_MAX_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  function automatic longint clamp_q31(input longint v);
    if (v > PI_MAX) return PI_MAX;
    if (v < PI_MIN) return PI_MIN;
    return v;
  endfunction

  // Rounds mu * p / 2^16 to nearest, ties away from zero on the magnitude.
  function automatic longint mul_round_q16(input longint mu, input longint p);
    bit               neg;
    longint unsigned  mag_mu;
    longint unsigned  mag_p;
    longint unsigned  r;
    neg = (mu < 0) != (p < 0);
    mag_mu = (mu < 0) ? -mu : mu;
    mag_p = (p < 0) ? -p : p;
    r = (mag_mu * mag_p + 64'd32768) >> 16;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Runs the pi/tau recurrence for one cosine and queues every order it yields.
  function automatic void predict_orders(input logic [COS_W-1:0] raw);
    longint        mu;
    longint        prev;
    longint        prev2;
    longint        pin;
    longint        tau;
    longint        t;
    longint        n;
    longint        count;
    order_result_t r;
    mu = longint'($signed(raw));
    if (mu > Q16_ONE) mu = Q16_ONE;
    if (mu < -Q16_ONE) mu = -Q16_ONE;
    count = longint'(order_count_model);
    if (count < 1) count = 1;
    if (count > ORDER_MAX_DEF) count = ORDER_MAX_DEF;
    prev = 0;
    prev2 = 0;
    for (n = 1; n <= count; n++) begin
      if (n == 1) begin
        pin = Q16_ONE;
      end else begin
        t = (2 * n - 1) * mul_round_q16(mu, prev) - n * prev2;
        pin = clamp_q31(t / (n - 1));
      end
      tau = clamp_q31(n * mul_round_q16(mu, pin) - (n + 1) * prev);
      r.order = n[ORDER_W-1:0];
      r.pi_n = pin[VAL_W-1:0];
      r.tau_n = tau[VAL_W-1:0];
      r.last = (n == count);
      expected_orders = {expected_orders, r};
      prev2 = prev;
      prev = pin;
    end
  endfunction

  function automatic logic [COS_W-1:0] random_cosine();
    int pick;
    int v;
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      v = int'($urandom_range(0, 131072)) - 65536;
    end else if (pick < 14) begin
      // Raw 18-bit patterns, about half of them outside [-1, 1].
      v = $urandom();
    end else if (pick < 17) begin
      v = ($urandom_range(0, 1) ? 65536 : -65536) + int'($urandom_range(0, 8)) - 4;
    end else begin
      v = int'($urandom_range(0, 512)) - 256;
    end
    return v[COS_W-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result %0d, %s: got %h, expected %h",
             results_checked, field, got, want);
    mismatch_count++;
  endtask

  // Result side: random stall bursts while idle_enable is set, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      sink_wait = hold_request;
      hold_request = 0;
    end
    if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait--;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_wait = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    order_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_orders.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_tdata[ORDER_W-1:0]), '0);
      end else begin
        want = expected_orders.pop_front();
        if (m_tdata[ORDER_W-1:0] !== want.order)
          report_mismatch("order_index", 64'(m_tdata[ORDER_W-1:0]), 64'(want.order));
        if (m_tdata[ORDER_W +: VAL_W] !== want.pi_n)
          report_mismatch("pi_value", 64'(m_tdata[ORDER_W +: VAL_W]), 64'(want.pi_n));
        if (m_tdata[ORDER_W + VAL_W +: VAL_W] !== want.tau_n)
          report_mismatch("tau_value", 64'(m_tdata[ORDER_W + VAL_W +: VAL_W]),
                          64'(want.tau_n));
        if (m_tlast !== want.last)
          report_mismatch("last_order", 64'(m_tlast), 64'(want.last));
        results_checked++;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_cosine(input logic [COS_W-1:0] raw);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - COS_W){1'b0}}, raw};
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_orders(raw);
    angles_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_orders.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_order_count(input logic [ORDER_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    order_count_model = value;
  endtask

  // The reset value of order_count gives the full 64 orders.
  task automatic test_reset_order_count();
    send_cosine(18'sd65536);
    send_cosine(-18'sd65536);
    wait_idle();
  endtask

  // Zero acts as one order; anything above the maximum acts as the maximum.
  task automatic test_order_count_limits();
    int limits[5] = '{0, 1, 65, 127, 2};
    foreach (limits[k]) begin
      write_order_count(ORDER_W'(limits[k]));
      send_cosine(18'sd40000);
      if (limits[k] < 64) send_cosine(-18'sd1);
      wait_idle();
    end
  endtask

  task automatic test_cosine_extremes();
    logic [COS_W-1:0] cosines[11] = '{
      18'sd65536, -18'sd65536, 18'sd0, 18'sd1, -18'sd1, 18'sd32768, -18'sd32768,
      18'sd65537, -18'sd65537, 18'h1FFFF, 18'h20000};
    write_order_count(7'd5);
    foreach (cosines[k]) send_cosine(cosines[k]);
    wait_idle();
  endtask

  // The result side holds off long enough for the block to stop taking items.
  task automatic test_output_stall();
    write_order_count(7'd3);
    hold_request = STALL_HOLD_CYCLES;
    repeat (6) send_cosine(random_cosine());
    wait_idle();
  endtask

  task automatic test_random_orders(input int item_goal);
    int stop_at;
    int pick;
    int value;
    int burst;
    stop_at = angles_sent + item_goal;
    while (angles_sent < stop_at) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) value = 64;
      else if (pick == 1) value = $urandom_range(65, 127);
      else if (pick == 2) value = 0;
      else value = $urandom_range(1, 10);
      write_order_count(ORDER_W'(value));
      burst = (value >= 64) ? 2 : $urandom_range(4, 10);
      repeat (burst) send_cosine(random_cosine());
      wait_idle();
    end
  endtask

  task automatic test_steady_stream();
    idle_enable = 1'b0;
    write_order_count(7'd4);
    repeat (15) send_cosine(random_cosine());
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_order_count();
    test_order_count_limits();
    test_cosine_extremes();
    test_output_stall();
    test_random_orders(90);
    test_steady_stream();
    $display("Covered %0d cosines and %0d order results, order counts 0 to 127,",
             angles_sent, results_checked);
    $display("cosines on and beyond both ends, and stalls on both sides of the block.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout: %0d results still awaited", expected_orders.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
